// ----- sv/kctd_pkg.sv -----
// Shared types and constants of the key chord tap detector.
package kctd_pkg;

   localparam int unsigned CODE_W = 8;
   localparam int unsigned CMD_W  = 2;
   localparam int unsigned ACT_W  = 2;
   localparam int unsigned PH_W   = 3;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned ADDR_W = 3;

   // Request commands.
   localparam logic [CMD_W-1:0] CMD_KEY_EVENT      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POLL_SWITCH    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POLL_TRANSLATE = 2'd2;

   // Key actions.
   localparam logic [ACT_W-1:0] ACT_DOWN = 2'd0;
   localparam logic [ACT_W-1:0] ACT_UP   = 2'd1;

   // Register indexes, taken from paddr[2].
   localparam logic REG_MODIFIER = 1'b0;
   localparam logic REG_SWITCH   = 1'b1;

   // Default key codes: left control and caps lock.
   localparam logic [CODE_W-1:0] LEFT_CONTROL_CODE = 8'd162;
   localparam logic [CODE_W-1:0] CAPS_LOCK_CODE    = 8'd20;

   typedef struct packed {
      logic [CODE_W-1:0] modifier_code;
      logic [CODE_W-1:0] switch_code;
   } cfg_type;

endpackage

// ----- sv/kctd_csr.sv -----
// Configuration registers of the key chord tap detector behind an APB-style port.
module kctd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [kctd_pkg::ADDR_W-1:0]   paddr,
   input  logic [kctd_pkg::DATA_W-1:0]   pwdata,
   output logic [kctd_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output kctd_pkg::cfg_type             cfg
);

   logic [kctd_pkg::CODE_W-1:0] modifier_ff;
   logic [kctd_pkg::CODE_W-1:0] switch_ff;
   logic                        write_en;
   logic [kctd_pkg::CODE_W-1:0] read_code;

   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         modifier_ff <= kctd_pkg::LEFT_CONTROL_CODE;
         switch_ff   <= kctd_pkg::CAPS_LOCK_CODE;
      end else if (write_en) begin
         unique case (paddr[2])
            kctd_pkg::REG_MODIFIER: modifier_ff <= pwdata[kctd_pkg::CODE_W-1:0];
            kctd_pkg::REG_SWITCH:   switch_ff   <= pwdata[kctd_pkg::CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         kctd_pkg::REG_MODIFIER: read_code = modifier_ff;
         kctd_pkg::REG_SWITCH:   read_code = switch_ff;
         default:                read_code = '0;
      endcase
   end

   // The lower address bits are not decoded.
   assign prdata = {{(kctd_pkg::DATA_W-kctd_pkg::CODE_W){1'b0}}, read_code};

   assign cfg.modifier_code = modifier_ff;
   assign cfg.switch_code   = switch_ff;

endmodule

// ----- sv/kctd_core.sv -----
// Chord state machine, sticky flags and result register of the key chord tap detector.
module kctd_core (
   input  logic                          clock,
   input  logic                          reset,
   input  kctd_pkg::cfg_type             cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kctd_pkg::CMD_W-1:0]    req_command,
   input  logic [kctd_pkg::CODE_W-1:0]   req_key_code,
   input  logic [kctd_pkg::ACT_W-1:0]    req_key_action,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_poll_answer,
   output logic                          rsp_switch_pending,
   output logic                          rsp_translate_pending,
   output logic [kctd_pkg::PH_W-1:0]     rsp_chord_state
);

   typedef enum logic [kctd_pkg::PH_W-1:0] {
      PH_IDLE    = 3'd0,
      PH_SW      = 3'd1,
      PH_BOTH    = 3'd2,
      PH_SW_REL  = 3'd3,
      PH_MOD_REL = 3'd4,
      PH_MOD     = 3'd5
   } phase_type;

   phase_type phase_ff, phase_in, key_phase;
   logic      switch_ff, switch_in, key_switch;
   logic      translate_ff, translate_in, key_translate;
   logic      valid_ff;
   logic      answer_ff, answer_in;
   logic      accept;
   logic      is_sw, is_mod, is_down, is_up;

   // The state only moves on an accepted request, and a request is only taken
   // once the previous result has gone, so the state registers double as the
   // result payload.
   assign req_ready = ~valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   assign is_sw   = (req_key_code == cfg.switch_code);
   assign is_mod  = (req_key_code == cfg.modifier_code);
   assign is_down = (req_key_action == kctd_pkg::ACT_DOWN);
   assign is_up   = (req_key_action == kctd_pkg::ACT_UP);

   // Key event transitions. A code matching both registers counts as the switch key.
   always_comb begin
      key_phase     = phase_ff;
      key_switch    = switch_ff;
      key_translate = translate_ff;
      if (is_sw || is_mod) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (is_down) key_phase = is_sw ? PH_SW : PH_MOD;
            end
            PH_SW: begin
               if (is_sw) begin
                  if (is_up) begin
                     key_switch = 1'b1;
                     key_phase  = PH_IDLE;
                  end
               end else if (is_down) begin
                  key_phase = PH_BOTH;
               end
            end
            PH_BOTH: begin
               if (is_up) key_phase = is_sw ? PH_SW_REL : PH_MOD_REL;
            end
            PH_SW_REL: begin
               if (is_sw) begin
                  if (is_down) key_phase = PH_BOTH;
               end else if (is_up) begin
                  key_translate = 1'b1;
                  key_phase     = PH_IDLE;
               end
            end
            PH_MOD_REL: begin
               if (is_sw) begin
                  if (is_up) begin
                     key_translate = 1'b1;
                     key_phase     = PH_IDLE;
                  end
               end else if (is_down) begin
                  key_phase = PH_BOTH;
               end
            end
            PH_MOD: begin
               if (is_sw) begin
                  if (is_down) key_phase = PH_BOTH;
               end else if (is_up) begin
                  key_phase = PH_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      switch_in    = switch_ff;
      translate_in = translate_ff;
      answer_in    = 1'b0;
      case (req_command)
         kctd_pkg::CMD_KEY_EVENT: begin
            phase_in     = key_phase;
            switch_in    = key_switch;
            translate_in = key_translate;
         end
         kctd_pkg::CMD_POLL_SWITCH: begin
            answer_in = switch_ff;
            switch_in = 1'b0;
         end
         kctd_pkg::CMD_POLL_TRANSLATE: begin
            answer_in    = translate_ff;
            translate_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         switch_ff    <= 1'b0;
         translate_ff <= 1'b0;
         valid_ff     <= 1'b0;
         answer_ff    <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            switch_ff    <= switch_in;
            translate_ff <= translate_in;
            answer_ff    <= answer_in;
         end
         if (accept) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_poll_answer       = answer_ff;
   assign rsp_switch_pending    = switch_ff;
   assign rsp_translate_pending = translate_ff;
   assign rsp_chord_state       = phase_ff;

`ifndef ASSERT_OFF
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while a result is still waiting");

   a_switch_poll_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == kctd_pkg::CMD_POLL_SWITCH) |=> !switch_ff)
      else $error("switch flag survived its poll");

   a_translate_set_by_key: assert property (@(posedge clock) disable iff (reset)
      $rose(translate_ff) |-> $past(accept && req_command == kctd_pkg::CMD_KEY_EVENT))
      else $error("translate flag set without a key event");

   a_state_holds_without_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_ff) && $stable(switch_ff) && $stable(translate_ff))
      else $error("state moved without an accepted request");
`endif

endmodule

// ----- sv/key_chord_tap_detector.sv -----
// Top level of the key chord tap detector: configuration registers and chord logic.
//
//   Channel   Ports                          Handshake
//   request   req_command/key_code/action    req_valid, req_ready
//   result    rsp_poll_answer ... chord      rsp_valid, rsp_ready
//   config    psel, penable, pwrite, paddr   APB write at access phase, pready tied high
//
// Each accepted request's result is registered and presented on the next cycle;
// one request per clock is sustained while rsp_ready is high, as there is one result register.
// A new request is taken whenever the result register is empty or is being emptied
// in the same cycle, so a stalled result holds off only further requests.
// Synchronous active-high reset returns the machine to idle with both flags clear and
// the key codes to left control (modifier) and caps lock (switch).
module key_chord_tap_detector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kctd_pkg::CMD_W-1:0]    req_command,
   input  logic [kctd_pkg::CODE_W-1:0]   req_key_code,
   input  logic [kctd_pkg::ACT_W-1:0]    req_key_action,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_poll_answer,
   output logic                          rsp_switch_pending,
   output logic                          rsp_translate_pending,
   output logic [kctd_pkg::PH_W-1:0]     rsp_chord_state,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [kctd_pkg::ADDR_W-1:0]   paddr,
   input  logic [kctd_pkg::DATA_W-1:0]   pwdata,
   output logic [kctd_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   // Key codes of the modifier and switch keys, as currently programmed.
   kctd_pkg::cfg_type cfg;

   // Register 0 (byte address 0) holds the modifier key, register 1 (address 4)
   // the switch key; the user must write both with no request in flight (not enforced).
   kctd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The chord machine: a switch tap alone sets the switch flag, a chord of both
   // keys sets the translate flag once both are released, and polls read and
   // clear one flag each.
   kctd_core u_core (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_command           (req_command),
      .req_key_code          (req_key_code),
      .req_key_action        (req_key_action),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_poll_answer       (rsp_poll_answer),
      .rsp_switch_pending    (rsp_switch_pending),
      .rsp_translate_pending (rsp_translate_pending),
      .rsp_chord_state       (rsp_chord_state)
   );

endmodule

// ----- test/key_chord_tap_detector_tb.sv -----
// Self-checking testbench for the key chord tap detector: directed gestures, then random traffic.
module key_chord_tap_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The run is abandoned if it has not finished by this point. A correct run with the
   // slowest idling takes well under a tenth of it.
   localparam int unsigned TIMEOUT_NS = 1_000_000;

   // Codes that the package does not name: the unused command and the key actions
   // that the block must ignore.
   localparam logic [kctd_pkg::CMD_W-1:0] CMD_UNUSED   = 2'd3;
   localparam logic [kctd_pkg::ACT_W-1:0] ACT_OTHER    = 2'd2;
   localparam logic [kctd_pkg::ACT_W-1:0] ACT_RESERVED = 2'd3;

   // The six phases of the chord machine, in the encoding of rsp_chord_state.
   typedef enum logic [kctd_pkg::PH_W-1:0] {
      PHASE_IDLE              = 3'd0,
      PHASE_SWITCH_HELD       = 3'd1,
      PHASE_BOTH_HELD         = 3'd2,
      PHASE_SWITCH_RELEASED   = 3'd3,
      PHASE_MODIFIER_RELEASED = 3'd4,
      PHASE_MODIFIER_HELD     = 3'd5
   } chord_phase_type;

   // What one request should produce on the result channel.
   typedef struct packed {
      logic                      poll_answer;
      logic                      switch_pending;
      logic                      translate_pending;
      logic [kctd_pkg::PH_W-1:0] chord_state;
   } chord_result_type;

   // Every input starts at a known value; from then on all of them are driven with
   // nonblocking assignments at the rising edge.
   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic                        req_ready;
   logic [kctd_pkg::CMD_W-1:0]  req_command    = kctd_pkg::CMD_KEY_EVENT;
   logic [kctd_pkg::CODE_W-1:0] req_key_code   = '0;
   logic [kctd_pkg::ACT_W-1:0]  req_key_action = kctd_pkg::ACT_DOWN;
   logic                        rsp_valid;
   logic                        rsp_ready      = 1'b0;
   logic                        rsp_poll_answer;
   logic                        rsp_switch_pending;
   logic                        rsp_translate_pending;
   logic [kctd_pkg::PH_W-1:0]   rsp_chord_state;
   logic                        psel           = 1'b0;
   logic                        penable        = 1'b0;
   logic                        pwrite         = 1'b0;
   logic [kctd_pkg::ADDR_W-1:0] paddr          = '0;
   logic [kctd_pkg::DATA_W-1:0] pwdata         = '0;
   logic [kctd_pkg::DATA_W-1:0] prdata;
   logic                        pready;

   // The testbench's own view of the block: the key codes it believes are configured,
   // the phase of the chord machine and the two sticky flags.
   logic [kctd_pkg::CODE_W-1:0] modifier_code_cfg = kctd_pkg::LEFT_CONTROL_CODE;
   logic [kctd_pkg::CODE_W-1:0] switch_code_cfg   = kctd_pkg::CAPS_LOCK_CODE;
   chord_phase_type             tracked_phase     = PHASE_IDLE;
   logic                        switch_latched    = 1'b0;
   logic                        translate_latched = 1'b0;

   // Results predicted for accepted requests, oldest first.
   chord_result_type pending_chord_results[$];

   int unsigned requests_sent = 0;
   int unsigned failures      = 0;
   int unsigned ready_hold    = 0;
   // While set, neither side idles, so requests and results flow back to back.
   bit          steady_flow   = 1'b0;

   key_chord_tap_detector u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_command           (req_command),
      .req_key_code          (req_key_code),
      .req_key_action        (req_key_action),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_poll_answer       (rsp_poll_answer),
      .rsp_switch_pending    (rsp_switch_pending),
      .rsp_translate_pending (rsp_translate_pending),
      .rsp_chord_state       (rsp_chord_state),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Number of cycles a side waits before its next request or result. At least half the
   // draws are zero so that back-to-back traffic is common; all are zero under steady_flow.
   function automatic int unsigned draw_wait();
      if (steady_flow)
         return 0;
      return $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
   endfunction

   // Advances the tracked state by one request and returns the result it should give.
   // A key code that matches both registers counts as the switch key, as in the block.
   function automatic chord_result_type predict_chord_result(
      input logic [kctd_pkg::CMD_W-1:0]  cmd,
      input logic [kctd_pkg::CODE_W-1:0] code,
      input logic [kctd_pkg::ACT_W-1:0]  act);
      chord_result_type res;
      logic             on_switch;
      logic             on_modifier;
      logic             down;
      logic             up;
      on_switch   = (code == switch_code_cfg);
      on_modifier = (code == modifier_code_cfg);
      down        = (act == kctd_pkg::ACT_DOWN);
      up          = (act == kctd_pkg::ACT_UP);
      res.poll_answer = 1'b0;
      if (cmd == kctd_pkg::CMD_KEY_EVENT && (on_switch || on_modifier)) begin
         case (tracked_phase)
            PHASE_IDLE: begin
               if (down && on_switch)
                  tracked_phase = PHASE_SWITCH_HELD;
               else if (down)
                  tracked_phase = PHASE_MODIFIER_HELD;
            end
            PHASE_SWITCH_HELD: begin
               // A lone tap of the switch key is what raises the switch flag.
               if (on_switch && up) begin
                  switch_latched = 1'b1;
                  tracked_phase  = PHASE_IDLE;
               end else if (!on_switch && down) begin
                  tracked_phase = PHASE_BOTH_HELD;
               end
            end
            PHASE_BOTH_HELD: begin
               if (up && on_switch)
                  tracked_phase = PHASE_SWITCH_RELEASED;
               else if (up)
                  tracked_phase = PHASE_MODIFIER_RELEASED;
            end
            PHASE_SWITCH_RELEASED: begin
               if (on_switch && down) begin
                  tracked_phase = PHASE_BOTH_HELD;
               end else if (!on_switch && up) begin
                  translate_latched = 1'b1;
                  tracked_phase     = PHASE_IDLE;
               end
            end
            PHASE_MODIFIER_RELEASED: begin
               if (on_switch && up) begin
                  translate_latched = 1'b1;
                  tracked_phase     = PHASE_IDLE;
               end else if (!on_switch && down) begin
                  tracked_phase = PHASE_BOTH_HELD;
               end
            end
            PHASE_MODIFIER_HELD: begin
               // Releasing the modifier on its own leaves both flags alone.
               if (on_switch && down)
                  tracked_phase = PHASE_BOTH_HELD;
               else if (!on_switch && up)
                  tracked_phase = PHASE_IDLE;
            end
            default: ;
         endcase
      end else if (cmd == kctd_pkg::CMD_POLL_SWITCH) begin
         res.poll_answer = switch_latched;
         switch_latched  = 1'b0;
      end else if (cmd == kctd_pkg::CMD_POLL_TRANSLATE) begin
         res.poll_answer   = translate_latched;
         translate_latched = 1'b0;
      end
      res.switch_pending    = switch_latched;
      res.translate_pending = translate_latched;
      res.chord_state       = tracked_phase;
      return res;
   endfunction

   // Result side. After each result the receiver draws a stall, counts it down with rsp_ready
   // low and then keeps rsp_ready high until the next result has been taken. Each
   // result is checked against the oldest prediction; values are read as they stood just
   // before the edge, so the order of processes within the time step does not matter.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold  = draw_wait();
      end else if (rsp_valid && rsp_ready) begin
         if (pending_chord_results.size() == 0) begin
            $error("result received with no request outstanding");
            failures++;
         end else begin
            chord_result_type exp_res;
            exp_res = pending_chord_results.pop_front();
            if (rsp_poll_answer !== exp_res.poll_answer) begin
               $error("poll_answer: expected %0d, actual %0d",
                      exp_res.poll_answer, rsp_poll_answer);
               failures++;
            end
            if (rsp_switch_pending !== exp_res.switch_pending) begin
               $error("switch_pending: expected %0d, actual %0d",
                      exp_res.switch_pending, rsp_switch_pending);
               failures++;
            end
            if (rsp_translate_pending !== exp_res.translate_pending) begin
               $error("translate_pending: expected %0d, actual %0d",
                      exp_res.translate_pending, rsp_translate_pending);
               failures++;
            end
            if (rsp_chord_state !== exp_res.chord_state) begin
               $error("chord_state: expected %0d, actual %0d",
                      exp_res.chord_state, rsp_chord_state);
               failures++;
            end
         end
         ready_hold  = draw_wait();
         rsp_ready  <= (ready_hold == 0);
      end else if (!rsp_ready) begin
         if (ready_hold > 1)
            ready_hold--;
         else
            rsp_ready <= 1'b1;
      end
   end

   // Sends one request. Called at a rising edge and returns at the edge where the request
   // was accepted, with req_valid still high, so that a following request with no gap
   // keeps valid high instead of dropping and raising it in the same time step.
   task automatic send_request(input logic [kctd_pkg::CMD_W-1:0]  cmd,
                               input logic [kctd_pkg::CODE_W-1:0] code,
                               input logic [kctd_pkg::ACT_W-1:0]  act);
      int unsigned gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_key_code   <= code;
      req_key_action <= act;
      do @(posedge clock); while (!req_ready);
      pending_chord_results.push_back(predict_chord_result(cmd, code, act));
      requests_sent++;
   endtask

   task automatic key_down(input logic [kctd_pkg::CODE_W-1:0] code);
      send_request(kctd_pkg::CMD_KEY_EVENT, code, kctd_pkg::ACT_DOWN);
   endtask

   task automatic key_up(input logic [kctd_pkg::CODE_W-1:0] code);
      send_request(kctd_pkg::CMD_KEY_EVENT, code, kctd_pkg::ACT_UP);
   endtask

   // A poll carries random key code and action bits, which the block must disregard.
   task automatic poll(input logic [kctd_pkg::CMD_W-1:0] cmd);
      send_request(cmd, kctd_pkg::CODE_W'($urandom), kctd_pkg::ACT_W'($urandom));
   endtask

   // A request with every field drawn at random, unused command and actions included.
   task automatic send_random_request();
      send_request(kctd_pkg::CMD_W'($urandom), kctd_pkg::CODE_W'($urandom),
                   kctd_pkg::ACT_W'($urandom));
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 5) == 0)
         send_random_request();
   endtask

   // Stops sending and waits until every predicted result has been taken, so that the
   // block is idle. Each request gives exactly one result, so nothing can still be in
   // flight after that; the short pause only lets the result register settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_chord_results.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Register writes use the usual setup and access cycles; pready is tied high, so the
   // register takes the value at the end of the access cycle. The bus then returns to
   // idle. The upper data bits are random and must not affect the 8-bit key code.
   task automatic write_key_code(input logic reg_index,
                                 input logic [kctd_pkg::CODE_W-1:0] code);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= {(kctd_pkg::DATA_W-kctd_pkg::CODE_W)'($urandom), code};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_index == kctd_pkg::REG_SWITCH)
         switch_code_cfg = code;
      else
         modifier_code_cfg = code;
      @(posedge clock);
   endtask

   // Reads a register back and compares it with the key code the testbench last wrote.
   task automatic read_key_code(input logic reg_index);
      logic [kctd_pkg::DATA_W-1:0] exp_data;
      exp_data = (reg_index == kctd_pkg::REG_SWITCH) ? kctd_pkg::DATA_W'(switch_code_cfg)
                                                     : kctd_pkg::DATA_W'(modifier_code_cfg);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {reg_index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== exp_data) begin
         $error("prdata: expected %0h, actual %0h", exp_data, prdata);
         failures++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Reprograms both key codes and reads them back. Only called with the block idle.
   task automatic set_key_codes(input logic [kctd_pkg::CODE_W-1:0] modifier_code,
                                input logic [kctd_pkg::CODE_W-1:0] switch_code);
      write_key_code(kctd_pkg::REG_MODIFIER, modifier_code);
      write_key_code(kctd_pkg::REG_SWITCH, switch_code);
      read_key_code(kctd_pkg::REG_MODIFIER);
      read_key_code(kctd_pkg::REG_SWITCH);
   endtask

   // One random gesture. Most are well formed (switch taps, chords in every press and
   // release order, modifier taps) with stray requests mixed in; the rest are bursts of
   // random requests and random events on the two configured keys.
   task automatic play_gesture();
      int unsigned                 kind;
      logic [kctd_pkg::CODE_W-1:0] first_key;
      logic [kctd_pkg::CODE_W-1:0] second_key;
      logic [kctd_pkg::CODE_W-1:0] early_key;
      logic [kctd_pkg::CODE_W-1:0] late_key;
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 1)) begin
         first_key  = switch_code_cfg;
         second_key = modifier_code_cfg;
      end else begin
         first_key  = modifier_code_cfg;
         second_key = switch_code_cfg;
      end
      if ($urandom_range(0, 1)) begin
         early_key = first_key;
         late_key  = second_key;
      end else begin
         early_key = second_key;
         late_key  = first_key;
      end
      case (kind)
         0, 1, 2: begin
            key_down(switch_code_cfg);
            maybe_noise();
            key_up(switch_code_cfg);
         end
         3, 4, 5: begin
            key_down(first_key);
            maybe_noise();
            key_down(second_key);
            maybe_noise();
            key_up(early_key);
            // Sometimes the released key goes down again before the chord ends.
            if ($urandom_range(0, 3) == 0) begin
               key_down(early_key);
               maybe_noise();
               key_up(early_key);
            end
            maybe_noise();
            key_up(late_key);
         end
         6: begin
            key_down(modifier_code_cfg);
            maybe_noise();
            key_up(modifier_code_cfg);
         end
         7: begin
            repeat ($urandom_range(1, 3)) send_random_request();
         end
         default: begin
            repeat ($urandom_range(1, 4))
               send_request(kctd_pkg::CMD_KEY_EVENT, first_key, kctd_pkg::ACT_W'($urandom));
         end
      endcase
      if ($urandom_range(0, 1))
         poll($urandom_range(0, 1) ? kctd_pkg::CMD_POLL_SWITCH
                                   : kctd_pkg::CMD_POLL_TRANSLATE);
   endtask

   // After reset both registers must hold the left control and caps lock codes.
   task automatic test_reset_values();
      read_key_code(kctd_pkg::REG_MODIFIER);
      read_key_code(kctd_pkg::REG_SWITCH);
   endtask

   // Walks the machine through every transition with the default key codes: a switch
   // tap, chords in both press orders with re-presses, a lone modifier tap, polls that
   // find the flag set and clear, other keys at the ends of the code range, ignored
   // actions, a repeated press and the unused command.
   task automatic test_default_gestures();
      key_down(kctd_pkg::CAPS_LOCK_CODE);
      key_down(kctd_pkg::CAPS_LOCK_CODE);
      key_up(kctd_pkg::CAPS_LOCK_CODE);
      poll(kctd_pkg::CMD_POLL_SWITCH);
      poll(kctd_pkg::CMD_POLL_SWITCH);
      key_down(kctd_pkg::LEFT_CONTROL_CODE);
      key_down(kctd_pkg::CAPS_LOCK_CODE);
      key_up(kctd_pkg::CAPS_LOCK_CODE);
      key_down(kctd_pkg::CAPS_LOCK_CODE);
      key_up(kctd_pkg::LEFT_CONTROL_CODE);
      key_down(kctd_pkg::LEFT_CONTROL_CODE);
      key_up(kctd_pkg::LEFT_CONTROL_CODE);
      key_up(kctd_pkg::CAPS_LOCK_CODE);
      poll(kctd_pkg::CMD_POLL_TRANSLATE);
      key_down(kctd_pkg::LEFT_CONTROL_CODE);
      key_up(kctd_pkg::LEFT_CONTROL_CODE);
      key_down(kctd_pkg::CAPS_LOCK_CODE);
      key_down(kctd_pkg::LEFT_CONTROL_CODE);
      key_up(kctd_pkg::CAPS_LOCK_CODE);
      key_up(kctd_pkg::LEFT_CONTROL_CODE);
      send_request(CMD_UNUSED, kctd_pkg::CAPS_LOCK_CODE, kctd_pkg::ACT_DOWN);
      key_down(kctd_pkg::CAPS_LOCK_CODE);
      send_request(kctd_pkg::CMD_KEY_EVENT, 8'h00, kctd_pkg::ACT_UP);
      send_request(kctd_pkg::CMD_KEY_EVENT, 8'hFF, kctd_pkg::ACT_DOWN);
      send_request(kctd_pkg::CMD_KEY_EVENT, kctd_pkg::CAPS_LOCK_CODE, ACT_OTHER);
      send_request(kctd_pkg::CMD_KEY_EVENT, kctd_pkg::CAPS_LOCK_CODE, ACT_RESERVED);
      poll(kctd_pkg::CMD_POLL_TRANSLATE);
   endtask

   // With the same code in both registers, every matching event is a switch key event:
   // a press and release is a switch tap, never a chord.
   task automatic test_shared_code();
      logic [kctd_pkg::CODE_W-1:0] shared_code;
      shared_code = kctd_pkg::CODE_W'($urandom);
      drain_results();
      set_key_codes(shared_code, shared_code);
      key_down(shared_code);
      key_down(shared_code);
      key_up(shared_code);
      poll(kctd_pkg::CMD_POLL_SWITCH);
      poll(kctd_pkg::CMD_POLL_TRANSLATE);
   endtask

   // A stretch of random gestures under one setting of the key codes. One gesture in
   // eight runs with no idling on either side.
   task automatic test_random_traffic(input logic [kctd_pkg::CODE_W-1:0] modifier_code,
                                      input logic [kctd_pkg::CODE_W-1:0] switch_code,
                                      input int unsigned                 request_count);
      int unsigned first_request;
      drain_results();
      set_key_codes(modifier_code, switch_code);
      first_request = requests_sent;
      while (requests_sent - first_request < request_count) begin
         steady_flow = ($urandom_range(0, 7) == 0);
         play_gesture();
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      logic [kctd_pkg::CODE_W-1:0] shared_code;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_default_gestures();
      test_shared_code();
      // The extremes of the code range first, then random codes, a shared code and
      // finally the reset defaults again.
      test_random_traffic(8'h00, 8'hFF, 170);
      test_random_traffic(8'hFF, 8'h00, 170);
      test_random_traffic(kctd_pkg::CODE_W'($urandom), kctd_pkg::CODE_W'($urandom), 170);
      shared_code = kctd_pkg::CODE_W'($urandom);
      test_random_traffic(shared_code, shared_code, 120);
      test_random_traffic(kctd_pkg::LEFT_CONTROL_CODE, kctd_pkg::CAPS_LOCK_CODE, 170);
      // Every prediction must have been met; the extra cycles would expose any result
      // that the block produces without a request behind it.
      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("PASS key_chord_tap_detector");
      else
         $display("FAIL key_chord_tap_detector");
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("FAIL key_chord_tap_detector");
      $finish;
   end

endmodule
